@@ hdl/cmi_pkg.sv @@
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared constants, codes and control structs of the complex 3x3 inverse.
// ----------------------------------------------------------------------------
package cmi_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 14;

  localparam int IDX_W     = 4;
  localparam int N_ENTRY   = 9;
  localparam int MUL_DIGIT = 4;

  localparam logic [IDX_W-1:0] LAST_INDEX = 4'd8;

  localparam logic [1:0] SRC_M   = 2'd0;
  localparam logic [1:0] SRC_ADJ = 2'd1;
  localparam logic [1:0] SRC_DET = 2'd2;

  localparam logic [2:0] DST_ADJ_RE = 3'd0;
  localparam logic [2:0] DST_ADJ_IM = 3'd1;
  localparam logic [2:0] DST_DET_RE = 3'd2;
  localparam logic [2:0] DST_DET_IM = 3'd3;
  localparam logic [2:0] DST_DEN    = 3'd4;
  localparam logic [2:0] DST_NUM_RE = 3'd5;
  localparam logic [2:0] DST_NUM_IM = 3'd6;

  typedef struct packed {
    logic             st_we;
    logic             ld_a;
    logic             ld_b;
    logic [1:0]       src;
    logic [IDX_W-1:0] idx;
    logic             im;
    logic             mul_start;
    logic             acc_en;
    logic             neg;
    logic             first;
    logic             last;
    logic [2:0]       dst;
    logic [IDX_W-1:0] dst_idx;
    logic             div_start;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/cmi_mul.sv @@
// ----------------------------------------------------------------------------
// cmi_mul
// Digit-serial signed multiplier, four multiplier bits per cycle.
// ----------------------------------------------------------------------------
module cmi_mul import cmi_pkg::*; #(
  parameter int OP_W  = 51,
  parameter int ACC_W = 103
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [OP_W-1:0]  a,
  input  logic signed [OP_W-1:0]  b,
  output logic                    done,
  output logic signed [ACC_W-1:0] prod
);

  localparam int PW = 2 * OP_W;

  logic [PW-1:0]   am;
  logic [PW-1:0]   pr;
  logic [PW-1:0]   part;
  logic [OP_W-1:0] bm;
  logic [OP_W-1:0] a_mag;
  logic [OP_W-1:0] b_mag;
  logic            sg;
  logic            busy;

  assign a_mag = a[OP_W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[OP_W-1] ? (~b + 1'b1) : b;

  always_comb begin
    part = '0;
    for (int i = 0; i < MUL_DIGIT; i++) begin
      if (bm[i]) begin
        part = part + (am << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bm == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am <= PW'(a_mag);
      bm <= b_mag;
      pr <= '0;
      sg <= a[OP_W-1] ^ b[OP_W-1];
    end else if (busy && bm != '0) begin
      pr <= pr + part;
      am <= am << MUL_DIGIT;
      bm <= bm >> MUL_DIGIT;
    end
  end

  assign done = busy && bm == '0;
  assign prod = sg ? -ACC_W'(pr) : ACC_W'(pr);

endmodule

@@ hdl/cmi_div.sv @@
// ----------------------------------------------------------------------------
// cmi_div
// Restoring divider, one quotient bit per cycle, with output saturation.
// ----------------------------------------------------------------------------
module cmi_div import cmi_pkg::*; #(
  parameter int NUM_W = 85,
  parameter int DEN_W = 102,
  parameter int OUT_W = 32,
  parameter int FRAC  = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [OUT_W-1:0] res,
  output logic                    ovf
);

  localparam int SH    = 2 * FRAC;
  localparam int NW    = NUM_W + SH;
  localparam int DW    = DEN_W + OUT_W;
  localparam int CW    = ((NW > DW) ? NW : DW) + 1;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [NUM_W-1:0] nmag;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    dv;
  logic [OUT_W-1:0] q;
  logic [OUT_W-1:0] lim;
  logic [OUT_W-1:0] mag;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic             big;

  assign nmag = num[NUM_W-1] ? (~num + 1'b1) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CNT_W'(1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(nmag) << SH;
      dv  <= CW'(den) << (OUT_W - 1);
      big <= (CW'(nmag) << SH) >= (CW'(den) << OUT_W);
      neg <= num[NUM_W-1];
      q   <= '0;
      cnt <= CNT_W'(OUT_W);
    end else if (busy) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        q   <= {q[OUT_W-2:0], 1'b1};
      end else begin
        q   <= {q[OUT_W-2:0], 1'b0};
      end
      dv  <= dv >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign lim = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  assign ovf = big || (q > lim);
  assign mag = ovf ? lim : q;
  assign res = neg ? -mag : mag;

endmodule

@@ hdl/cmi_dpath.sv @@
// ----------------------------------------------------------------------------
// cmi_dpath
// Entry store, cofactor/determinant registers, multiplier, dividers, output.
// ----------------------------------------------------------------------------
module cmi_dpath import cmi_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic signed [IN_WIDTH-1:0]  entry_re,
  input  logic signed [IN_WIDTH-1:0]  entry_im,
  input  logic [IDX_W-1:0]            entry_index,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [OUT_WIDTH-1:0] result_re,
  output logic signed [OUT_WIDTH-1:0] result_im,
  output logic [IDX_W-1:0]            result_index,
  output logic                        singular,
  output logic                        overflow,
  output logic                        last_entry
);

  localparam int W     = IN_WIDTH;
  localparam int ADJ_W = 2 * W + 2;
  localparam int DET_W = 3 * W + 3;
  localparam int NUM_W = 5 * W + 5;
  localparam int DEN_W = 6 * W + 6;
  localparam int ACC_W = 6 * W + 7;

  logic signed [W-1:0]     st_re  [N_ENTRY];
  logic signed [W-1:0]     st_im  [N_ENTRY];
  logic signed [ADJ_W-1:0] adj_re [N_ENTRY];
  logic signed [ADJ_W-1:0] adj_im [N_ENTRY];
  logic signed [DET_W-1:0] det_re;
  logic signed [DET_W-1:0] det_im;
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] num_re;
  logic signed [NUM_W-1:0] num_im;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] prod;
  logic signed [DET_W-1:0] opa;
  logic signed [DET_W-1:0] opb;
  logic signed [DET_W-1:0] rd;
  logic [W-1:0]            st_sel;
  logic [ADJ_W-1:0]        adj_sel;
  logic                    mul_done;
  logic                    dre_done;
  logic                    dim_done;
  logic                    dre_ovf;
  logic                    dim_ovf;
  logic signed [OUT_WIDTH-1:0] dre_res;
  logic signed [OUT_WIDTH-1:0] dim_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_ENTRY; i++) begin
        st_re[i] <= '0;
        st_im[i] <= '0;
      end
    end else if (cmd.st_we) begin
      st_re[entry_index] <= entry_re;
      st_im[entry_index] <= entry_im;
    end
  end

  always_comb begin
    st_sel  = cmd.im ? st_im[cmd.idx] : st_re[cmd.idx];
    adj_sel = cmd.im ? adj_im[cmd.idx] : adj_re[cmd.idx];
    case (cmd.src)
      SRC_M:   rd = {{(DET_W-W){st_sel[W-1]}}, st_sel};
      SRC_ADJ: rd = {{(DET_W-ADJ_W){adj_sel[ADJ_W-1]}}, adj_sel};
      SRC_DET: rd = cmd.im ? det_im : det_re;
      default: rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      opa <= rd;
    end
    if (cmd.ld_b) begin
      opb <= rd;
    end
  end

  cmi_mul #(
    .OP_W  (DET_W),
    .ACC_W (ACC_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (prod)
  );

  assign acc_next = (cmd.first ? '0 : acc) + (cmd.neg ? -prod : prod);

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= acc_next;
      if (cmd.last) begin
        case (cmd.dst)
          DST_ADJ_RE: adj_re[cmd.dst_idx] <= acc_next[ADJ_W-1:0];
          DST_ADJ_IM: adj_im[cmd.dst_idx] <= acc_next[ADJ_W-1:0];
          DST_DET_RE: det_re <= acc_next[DET_W-1:0];
          DST_DET_IM: det_im <= acc_next[DET_W-1:0];
          DST_DEN:    den    <= acc_next[DEN_W-1:0];
          DST_NUM_RE: num_re <= acc_next[NUM_W-1:0];
          DST_NUM_IM: num_im <= acc_next[NUM_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  cmi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .OUT_W (OUT_WIDTH),
    .FRAC  (FRAC_BITS)
  ) u_div_re (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_re),
    .den   (den),
    .done  (dre_done),
    .res   (dre_res),
    .ovf   (dre_ovf)
  );

  cmi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .OUT_W (OUT_WIDTH),
    .FRAC  (FRAC_BITS)
  ) u_div_im (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_im),
    .den   (den),
    .done  (dim_done),
    .res   (dim_res),
    .ovf   (dim_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_index <= cmd.dst_idx;
      last_entry   <= cmd.dst_idx == LAST_INDEX;
      singular     <= sts.den_zero;
      result_re    <= sts.den_zero ? '0 : dre_res;
      result_im    <= sts.den_zero ? '0 : dim_res;
      overflow     <= !sts.den_zero && (dre_ovf || dim_ovf);
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = dre_done && dim_done;
  assign sts.den_zero = den == '0;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ hdl/cmi_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmi_ctrl
// Sequencer: cofactors, determinant, norm, then per entry numerator and divide unless singular.
// ----------------------------------------------------------------------------
module cmi_ctrl import cmi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] entry_index,
  output logic             in_ready,
  input  sts_t             sts,
  output cmd_t             cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDA   = 4'd1;
  localparam logic [3:0] S_LDB   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_MWAIT = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] PH_COF = 2'd0;
  localparam logic [1:0] PH_DET = 2'd1;
  localparam logic [1:0] PH_DEN = 2'd2;
  localparam logic [1:0] PH_NUM = 2'd3;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_next;
  logic [3:0]       t;
  logic [3:0]       t_next;

  logic [1:0]       a_src;
  logic [1:0]       b_src;
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] b_idx;
  logic             a_im;
  logic             b_im;
  logic             neg;
  logic             first;
  logic             last;
  logic [2:0]       dst;
  logic [3:0]       last_t;
  logic [1:0]       r;
  logic [1:0]       c;
  logic [IDX_W-1:0] ia;
  logic [IDX_W-1:0] ib;
  logic [IDX_W-1:0] ic;
  logic [IDX_W-1:0] id;
  logic [3:0]       tt;
  logic             hi;

  function automatic logic [1:0] nxt3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [IDX_W-1:0] pos(input logic [1:0] x, input logic [1:0] y);
    return ({2'b00, x} << 1) + {2'b00, x} + {2'b00, y};
  endfunction

  always_comb begin
    case (k)
      4'd0:    begin r = 2'd0; c = 2'd0; end
      4'd1:    begin r = 2'd0; c = 2'd1; end
      4'd2:    begin r = 2'd0; c = 2'd2; end
      4'd3:    begin r = 2'd1; c = 2'd0; end
      4'd4:    begin r = 2'd1; c = 2'd1; end
      4'd5:    begin r = 2'd1; c = 2'd2; end
      4'd6:    begin r = 2'd2; c = 2'd0; end
      4'd7:    begin r = 2'd2; c = 2'd1; end
      4'd8:    begin r = 2'd2; c = 2'd2; end
      default: begin r = 2'd0; c = 2'd0; end
    endcase
    ia = pos(nxt3(c), nxt3(r));
    ib = pos(nxt3(nxt3(c)), nxt3(nxt3(r)));
    ic = pos(nxt3(c), nxt3(nxt3(r)));
    id = pos(nxt3(nxt3(c)), nxt3(r));
    hi = t >= 4'd6;
    tt = hi ? t - 4'd6 : t;

    case (phase)
      PH_COF: begin
        a_src  = SRC_M;
        b_src  = SRC_M;
        a_idx  = t[1] ? ic : ia;
        b_idx  = t[1] ? id : ib;
        a_im   = t[0];
        b_im   = t[0] ^ t[2];
        neg    = t[2] ? t[1] : (t[0] ^ t[1]);
        first  = t[1:0] == 2'd0;
        last   = t[1:0] == 2'd3;
        dst    = t[2] ? DST_ADJ_IM : DST_ADJ_RE;
        last_t = 4'd7;
      end
      PH_DET: begin
        a_src  = SRC_ADJ;
        b_src  = SRC_M;
        a_idx  = pos(tt[2:1], 2'd0);
        b_idx  = {2'b00, tt[2:1]};
        a_im   = tt[0];
        b_im   = tt[0] ^ hi;
        neg    = !hi && tt[0];
        first  = tt == 4'd0;
        last   = tt == 4'd5;
        dst    = hi ? DST_DET_IM : DST_DET_RE;
        last_t = 4'd11;
      end
      PH_DEN: begin
        a_src  = SRC_DET;
        b_src  = SRC_DET;
        a_idx  = '0;
        b_idx  = '0;
        a_im   = t[0];
        b_im   = t[0];
        neg    = 1'b0;
        first  = t == 4'd0;
        last   = t == 4'd1;
        dst    = DST_DEN;
        last_t = 4'd1;
      end
      default: begin
        a_src  = SRC_DET;
        b_src  = SRC_ADJ;
        a_idx  = '0;
        b_idx  = k;
        a_im   = t[0];
        b_im   = t[0] ^ t[1];
        neg    = t == 4'd3;
        first  = !t[0];
        last   = t[0];
        dst    = t[1] ? DST_NUM_IM : DST_NUM_RE;
        last_t = 4'd3;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    k_next     = k;
    t_next     = t;
    cmd        = '0;
    in_ready   = 1'b0;

    cmd.src     = (state == S_LDB) ? b_src : a_src;
    cmd.idx     = (state == S_LDB) ? b_idx : a_idx;
    cmd.im      = (state == S_LDB) ? b_im : a_im;
    cmd.neg     = neg;
    cmd.first   = first;
    cmd.last    = last;
    cmd.dst     = dst;
    cmd.dst_idx = k;

    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.st_we = in_valid && entry_index <= LAST_INDEX;
        if (in_valid && entry_index == LAST_INDEX) begin
          phase_next = PH_COF;
          k_next     = '0;
          t_next     = '0;
          state_next = S_LDA;
        end
      end
      S_LDA: begin
        cmd.ld_a   = 1'b1;
        state_next = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          cmd.acc_en = 1'b1;
          state_next = S_LDA;
          if (t == last_t) begin
            t_next = '0;
            case (phase)
              PH_COF: begin
                if (k == LAST_INDEX) begin
                  phase_next = PH_DET;
                  k_next     = '0;
                end else begin
                  k_next = k + 1'b1;
                end
              end
              PH_DET:  phase_next = PH_DEN;
              PH_DEN:  state_next = S_CHK;
              default: state_next = S_DIV;
            endcase
          end else begin
            t_next = t + 1'b1;
          end
        end
      end
      S_CHK: begin
        k_next = '0;
        t_next = '0;
        if (sts.den_zero) begin
          state_next = S_OUT;
        end else begin
          phase_next = PH_NUM;
          state_next = S_LDA;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (k == LAST_INDEX) begin
            state_next = S_IDLE;
          end else begin
            k_next = k + 1'b1;
            t_next = '0;
            if (!sts.den_zero) begin
              state_next = S_LDA;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_COF;
      k     <= '0;
      t     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      k     <= k_next;
      t     <= t_next;
    end
  end

`ifndef ASSERT_OFF
  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && entry_index == LAST_INDEX) |=>
      (state == S_LDA && phase == PH_COF && k == '0 && t == '0))
    else $error("trigger item did not start the cofactor pass");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    k <= LAST_INDEX)
    else $error("entry counter out of range");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    t <= last_t)
    else $error("term counter beyond last term of phase");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && k == LAST_INDEX) |=> (state == S_IDLE && in_ready))
    else $error("sequencer did not return to idle after the ninth result");
`endif

endmodule

@@ hdl/complex_3x3_matrix_inverse.sv @@
// ----------------------------------------------------------------------------
// complex_3x3_matrix_inverse
// Inverse of a complex 3x3 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one matrix entry per item, Q1.14 re/im,
// tagged with its row-major index. Indexes 0..7 are stored;
// index 8 is stored and starts a run. Indexes 9..15 are dropped.
// Output channel (out_valid/out_ready): nine items per run in row-major
// order, Q17.14 re/im truncated toward zero, with saturation (overflow),
// singular and last_entry flags.
// A run performs 122 real products on one digit-serial multiplier (four bits
// per cycle, stopping when the multiplier operand runs out), each after an
// operand fetch (load A, load B, start), and one divide per result (real
// and imaginary in parallel). A singular matrix skips numerators and divides.
// in_ready is high only between runs; it rises again as soon as the ninth
// result is registered. A stalled receiver holds the sequencer at its
// output register. Reset clears the entry store to zero and empties the
// output register.
// ----------------------------------------------------------------------------
module complex_3x3_matrix_inverse import cmi_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  entry_re,
  input  logic signed [IN_WIDTH-1:0]  entry_im,
  input  logic [IDX_W-1:0]            entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] result_re,
  output logic signed [OUT_WIDTH-1:0] result_im,
  output logic [IDX_W-1:0]            result_index,
  output logic                        singular,
  output logic                        overflow,
  output logic                        last_entry
);

  cmd_t cmd;
  sts_t sts;

  cmi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .entry_index (entry_index),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  cmi_dpath #(
    .IN_WIDTH  (IN_WIDTH),
    .OUT_WIDTH (OUT_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .entry_re     (entry_re),
    .entry_im     (entry_im),
    .entry_index  (entry_index),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .result_re    (result_re),
    .result_im    (result_im),
    .result_index (result_index),
    .singular     (singular),
    .overflow     (overflow),
    .last_entry   (last_entry)
  );

endmodule

@@ verif/complex_3x3_matrix_inverse_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_3x3_matrix_inverse_chk
// Watches both channels of the complex 3x3 inverse, keeps its own entry
// store, predicts the nine inverse entries on every index-8 item with exact
// wide arithmetic and compares each output item with the oldest prediction.
// ----------------------------------------------------------------------------
module complex_3x3_matrix_inverse_chk import cmi_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [IN_WIDTH_DEF-1:0]  entry_re,
  input  logic signed [IN_WIDTH_DEF-1:0]  entry_im,
  input  logic [IDX_W-1:0]                entry_index,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic signed [OUT_WIDTH_DEF-1:0] result_re,
  input  logic signed [OUT_WIDTH_DEF-1:0] result_im,
  input  logic [IDX_W-1:0]                result_index,
  input  logic                            singular,
  input  logic                            overflow,
  input  logic                            last_entry,
  output int                              fail_count,
  output int                              pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [OUT_WIDTH_DEF-1:0] re;
    logic signed [OUT_WIDTH_DEF-1:0] im;
    logic [IDX_W-1:0]                idx;
    logic                            sing;
    logic                            ovf;
    logic                            last;
  } inv_entry_t;

  logic signed [IN_WIDTH_DEF-1:0] store_re [N_ENTRY];
  logic signed [IN_WIDTH_DEF-1:0] store_im [N_ENTRY];
  inv_entry_t inverse_q[$];

  function automatic logic signed [OUT_WIDTH_DEF-1:0] sat_quot(wide_t num, wide_t den,
                                                             inout logic ovf);
    wide_t mag, lim;
    logic  neg;
    neg = num < 0;
    mag = (neg ? -num : num) / den;
    lim = neg ? (wide_t'(1) <<< (OUT_WIDTH_DEF - 1))
              : (wide_t'(1) <<< (OUT_WIDTH_DEF - 1)) - 1;
    if (mag > lim) begin
      mag = lim;
      ovf = 1'b1;
    end
    mag = neg ? -mag : mag;
    return mag[OUT_WIDTH_DEF-1:0];
  endfunction

  task automatic predict_inverse();
    wide_t mre [3][3], mim [3][3], are [3][3], aim [3][3];
    wide_t dre, dim, den, nre, nim;
    int a1, a2, b1, b2;
    inv_entry_t e;
    for (int k = 0; k < 9; k++) begin
      mre[k/3][k%3] = wide_t'(store_re[k]);
      mim[k/3][k%3] = wide_t'(store_im[k]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a1 = (c + 1) % 3; a2 = (c + 2) % 3;
        b1 = (r + 1) % 3; b2 = (r + 2) % 3;
        are[r][c] = (mre[a1][b1] * mre[a2][b2] - mim[a1][b1] * mim[a2][b2])
                  - (mre[a1][b2] * mre[a2][b1] - mim[a1][b2] * mim[a2][b1]);
        aim[r][c] = (mre[a1][b1] * mim[a2][b2] + mim[a1][b1] * mre[a2][b2])
                  - (mre[a1][b2] * mim[a2][b1] + mim[a1][b2] * mre[a2][b1]);
      end
    end
    dre = 0;
    dim = 0;
    for (int c = 0; c < 3; c++) begin
      dre += mre[0][c] * are[c][0] - mim[0][c] * aim[c][0];
      dim += mre[0][c] * aim[c][0] + mim[0][c] * are[c][0];
    end
    den = dre * dre + dim * dim;
    for (int k = 0; k < 9; k++) begin
      e.idx  = IDX_W'(k);
      e.last = (k == 8);
      e.ovf  = 1'b0;
      if (den == 0) begin
        e.re   = '0;
        e.im   = '0;
        e.sing = 1'b1;
      end else begin
        nre = are[k/3][k%3] * dre + aim[k/3][k%3] * dim;
        nim = aim[k/3][k%3] * dre - are[k/3][k%3] * dim;
        e.re   = sat_quot(nre <<< (2 * FRAC_BITS_DEF), den, e.ovf);
        e.im   = sat_quot(nim <<< (2 * FRAC_BITS_DEF), den, e.ovf);
        e.sing = 1'b0;
      end
      inverse_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    inv_entry_t e;
    if (rst) begin
      for (int k = 0; k < N_ENTRY; k++) begin
        store_re[k] = '0;
        store_im[k] = '0;
      end
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready && entry_index <= LAST_INDEX) begin
        store_re[entry_index] = entry_re;
        store_im[entry_index] = entry_im;
        if (entry_index == LAST_INDEX) predict_inverse();
      end
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output item idx=%0d", result_index);
          fail_count <= fail_count + 1;
        end else begin
          e = inverse_q.pop_front();
          if (result_re !== e.re || result_im !== e.im || result_index !== e.idx ||
              singular !== e.sing || overflow !== e.ovf || last_entry !== e.last) begin
            if (fail_count < 10)
              $display("mismatch: exp re=%0d im=%0d idx=%0d s=%0b o=%0b l=%0b,",
                       e.re, e.im, e.idx, e.sing, e.ovf, e.last,
                       " got re=%0d im=%0d idx=%0d s=%0b o=%0b l=%0b",
                       result_re, result_im, result_index, singular, overflow,
                       last_entry);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= inverse_q.size();
    end
  end

endmodule

@@ verif/complex_3x3_matrix_inverse_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_3x3_matrix_inverse_tb
// Loads matrices entry by entry into the complex 3x3 inverse: singular,
// identity, extreme and near-singular cases, ignored indexes, then random
// matrices with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module complex_3x3_matrix_inverse_tb import cmi_pkg::*;;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [IN_WIDTH_DEF-1:0]  entry_re, entry_im;
  logic [IDX_W-1:0]                entry_index;
  logic signed [OUT_WIDTH_DEF-1:0] result_re, result_im;
  logic [IDX_W-1:0]                result_index;
  logic singular, overflow, last_entry;
  int   fail_count, pending;
  int   sent;

  complex_3x3_matrix_inverse u_top (.*);

  complex_3x3_matrix_inverse_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      3: return 16'sh4000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [15:0] re, logic [15:0] im, logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    entry_re    <= re;
    entry_im    <= im;
    entry_index <= idx;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int n;
    logic [IDX_W-1:0] idx;
    rst = 1'b1;
    in_valid = 1'b0;
    entry_re = '0;
    entry_im = '0;
    entry_index = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero store: singular
    send(16'h0, 16'h0, LAST_INDEX);
    // identity
    for (int k = 0; k < 9; k++)
      send((k % 4 == 0) ? 16'sh4000 : 16'h0, 16'h0, IDX_W'(k));
    // extremes
    send(16'sh7fff, 16'sh8000, 4'd0);
    send(16'sh8000, 16'sh7fff, LAST_INDEX);
    // near-singular upper block, saturates
    send(16'sh7fff, 16'h0, 4'd0);
    send(16'sh7ffe, 16'h0, 4'd1);
    send(16'sh7fff, 16'h0, 4'd3);
    send(16'sh7fff, 16'h0, 4'd4);
    // ignored indexes
    send(16'sh1234, 16'sh4321, 4'd9);
    send(16'shffff, 16'shffff, 4'd15);
    send(16'sh0001, 16'h0, LAST_INDEX);

    while (sent < 255) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 9) < 7 ? 8 : $urandom_range(0, 7);
        for (int k = 0; k < n; k++) begin
          idx = (n == 8) ? IDX_W'(k) : IDX_W'($urandom_range(0, 7));
          send(rand_val(), rand_val(), idx);
        end
        send(rand_val(), rand_val(), LAST_INDEX);
      end else begin
        send(rand_val(), rand_val(), IDX_W'($urandom_range(0, 15)));
      end
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
